// ===== rtl/mps_pkg.sv =====
// shared types and constants for the majority protocol block
// no dependencies
package mps_pkg;

    localparam int MAX_AGENTS = 1024;
    localparam int AW         = $clog2(MAX_AGENTS);
    localparam int CW         = $clog2(MAX_AGENTS + 1);
    localparam int CFG_W      = 11;
    localparam int CFG_RESET  = 1024;

    typedef enum logic [1:0] {
        OP_YES   = 2'd0,
        OP_NO    = 2'd1,
        OP_UND   = 2'd2,
        OP_EMPTY = 2'd3
    } opinion_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_WR2
    } state_t;

    typedef enum logic {
        FN_WRITE    = 1'b0,
        FN_INTERACT = 1'b1
    } func_t;

    // old and new opinion of the two agents touched by one item
    typedef struct packed {
        opinion_t old_a;
        opinion_t new_a;
        opinion_t old_b;
        opinion_t new_b;
    } tally_upd_t;

    // agent count limited to 1..MAX_AGENTS
    function automatic logic [CW-1:0] clamp_count(input logic [CFG_W-1:0] c);
        logic [CW-1:0] r;
        if (c == '0)
            r = CW'(1);
        else if (32'(c) > 32'(MAX_AGENTS))
            r = CW'(MAX_AGENTS);
        else
            r = CW'(c);
        return r;
    endfunction

endpackage

// ===== rtl/mps_store.sv =====
// agent opinion memory: one write port, two registered read ports
// depends on mps_pkg
module mps_store (
    input  logic             clk,
    input  logic             we,
    input  logic [mps_pkg::AW-1:0] waddr,
    input  mps_pkg::opinion_t       wdata,
    input  logic             re,
    input  logic [mps_pkg::AW-1:0] raddr_a,
    input  logic [mps_pkg::AW-1:0] raddr_b,
    output mps_pkg::opinion_t       rdata_a,
    output mps_pkg::opinion_t       rdata_b
);
    import mps_pkg::*;

    opinion_t mem [MAX_AGENTS];
    opinion_t rdata_a_reg;
    opinion_t rdata_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_a_reg <= mem[raddr_a];
            rdata_b_reg <= mem[raddr_b];
        end
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

// ===== rtl/mps_tally.sv =====
// running opinion totals and consensus detection
// depends on mps_pkg
module mps_tally (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  mps_pkg::tally_upd_t upd,
    input  logic [mps_pkg::CW-1:0] eff_count,
    output logic [mps_pkg::CW-1:0] yes_total,
    output logic [mps_pkg::CW-1:0] no_total,
    output logic [mps_pkg::CW-1:0] und_total,
    output logic                consensus,
    output mps_pkg::opinion_t   consensus_op
);
    import mps_pkg::*;

    logic [CW-1:0] yes_reg, yes_next;
    logic [CW-1:0] no_reg, no_next;
    logic [CW-1:0] und_reg, und_next;
    logic          cons_reg, cons_next;
    opinion_t      cop_reg, cop_next;

    function automatic logic [1:0] hits(input opinion_t x, input opinion_t p,
                                        input opinion_t q);
        hits = {1'b0, x == p} + {1'b0, x == q};
    endfunction

    always_comb
    begin
        yes_next = yes_reg + CW'(hits(OP_YES, upd.new_a, upd.new_b))
                           - CW'(hits(OP_YES, upd.old_a, upd.old_b));
        no_next  = no_reg  + CW'(hits(OP_NO, upd.new_a, upd.new_b))
                           - CW'(hits(OP_NO, upd.old_a, upd.old_b));
        und_next = und_reg + CW'(hits(OP_UND, upd.new_a, upd.new_b))
                           - CW'(hits(OP_UND, upd.old_a, upd.old_b));
        // yes wins over no, no over undecided
        cons_next = 1'b1;
        cop_next  = OP_YES;
        if (yes_next == eff_count)
            cop_next = OP_YES;
        else if (no_next == eff_count)
            cop_next = OP_NO;
        else if (und_next == eff_count)
            cop_next = OP_UND;
        else
            cons_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            yes_reg  <= '0;
            no_reg   <= '0;
            und_reg  <= '0;
            cons_reg <= 1'b0;
            cop_reg  <= OP_YES;
        end
        else if (load)
        begin
            yes_reg  <= yes_next;
            no_reg   <= no_next;
            und_reg  <= und_next;
            cons_reg <= cons_next;
            cop_reg  <= cop_next;
        end
    end

    assign yes_total    = yes_reg;
    assign no_total     = no_reg;
    assign und_total    = und_reg;
    assign consensus    = cons_reg;
    assign consensus_op = cop_reg;

endmodule

// ===== rtl/majority_protocol_simulator.sv =====
// approximate majority population protocol over a store of agents
// depends on mps_pkg, mps_store, mps_tally
//
// usage:
//   input words are taken on start while busy is low: func 0 writes
//   new_opinion to agent index_a, func 1 lets agents index_a and index_b
//   interact. each word gives one result, shown for one cycle with done
//   high: the three opinion totals, the consensus flag and opinion, and
//   index_error when an index is at or beyond the agent count (the word
//   then changes nothing).
//   done is registered from the execute state. a new word is taken only when
//   busy is low again; an interaction of yes with no adds a second write state,
//   since both agents are rewritten through the single write port of the store.
//   the agent count is written on cfg_data with cfg_valid; cfg_ready is
//   always high. write it only while idle.
//   after reset the store is swept to empty, one agent per cycle, over all
//   MAX_AGENTS (1024) agents with busy high; totals reset to zero and the
//   agent count to 1024. the receiver cannot stall: results are not held.
module majority_protocol_simulator (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        func,
    input  logic [mps_pkg::AW-1:0]      index_a,
    input  logic [mps_pkg::AW-1:0]      index_b,
    input  logic [1:0]                  new_opinion,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [mps_pkg::CFG_W-1:0]   cfg_data,
    output logic                        done,
    output logic [mps_pkg::CW-1:0]      yes_count,
    output logic [mps_pkg::CW-1:0]      no_count,
    output logic [mps_pkg::CW-1:0]      undecided_count,
    output logic                        consensus,
    output logic [1:0]                  consensus_opinion,
    output logic                        index_error
);
    import mps_pkg::*;

    state_t          state_reg, state_next;
    logic [AW-1:0]   clr_reg, clr_next;
    logic [CW-1:0]   eff_reg;
    logic            done_reg;
    func_t           func_reg;
    logic [AW-1:0]   ia_reg;
    logic [AW-1:0]   ib_reg;
    opinion_t        op_reg;
    logic            err_reg;

    logic            accept;
    logic            acc_err;
    opinion_t        rd_a;
    opinion_t        rd_b;

    // rule decode during execute
    tally_upd_t      upd;
    logic            wr_first;
    logic            wr_first_b;
    opinion_t        wr_first_data;
    logic            need_wr2;

    // store write port
    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    opinion_t        mem_wdata;

    opinion_t        cons_op;

    assign accept    = start && !busy;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        acc_err = CW'(index_a) >= eff_reg;
        if (func_t'(func) == FN_INTERACT && CW'(index_b) >= eff_reg)
            acc_err = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eff_reg <= clamp_count(CFG_W'(CFG_RESET));
        end
        else if (cfg_valid && cfg_ready)
        begin
            eff_reg <= clamp_count(cfg_data);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg <= func_t'(func);
            ia_reg   <= index_a;
            ib_reg   <= index_b;
            op_reg   <= opinion_t'(new_opinion);
            err_reg  <= acc_err;
        end
    end

    mps_store u_store (
        .clk     (clk),
        .we      (mem_we),
        .waddr   (mem_waddr),
        .wdata   (mem_wdata),
        .re      (accept),
        .raddr_a (index_a),
        .raddr_b (index_b),
        .rdata_a (rd_a),
        .rdata_b (rd_b)
    );

    // protocol rule on the two read opinions
    always_comb
    begin
        upd.old_a     = rd_a;
        upd.new_a     = rd_a;
        upd.old_b     = rd_b;
        upd.new_b     = rd_b;
        wr_first      = 1'b0;
        wr_first_b    = 1'b0;
        wr_first_data = OP_EMPTY;
        need_wr2      = 1'b0;
        if (!err_reg)
        begin
            if (func_reg == FN_WRITE)
            begin
                upd.old_b     = OP_EMPTY;
                upd.new_b     = OP_EMPTY;
                upd.new_a     = op_reg;
                wr_first      = 1'b1;
                wr_first_data = op_reg;
            end
            else if (ia_reg != ib_reg)
            begin
                if ((rd_a == OP_YES || rd_a == OP_NO) && rd_b == OP_UND)
                begin
                    upd.new_b     = rd_a;
                    wr_first      = 1'b1;
                    wr_first_b    = 1'b1;
                    wr_first_data = rd_a;
                end
                else if (rd_a == OP_UND && (rd_b == OP_YES || rd_b == OP_NO))
                begin
                    upd.new_a     = rd_b;
                    wr_first      = 1'b1;
                    wr_first_data = rd_b;
                end
                else if ((rd_a == OP_YES && rd_b == OP_NO) ||
                         (rd_a == OP_NO && rd_b == OP_YES))
                begin
                    upd.new_a     = OP_UND;
                    upd.new_b     = OP_UND;
                    wr_first      = 1'b1;
                    wr_first_data = OP_UND;
                    need_wr2      = 1'b1;
                end
            end
        end
    end

    mps_tally u_tally (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (state_reg == ST_EXEC),
        .upd          (upd),
        .eff_count    (eff_reg),
        .yes_total    (yes_count),
        .no_total     (no_count),
        .und_total    (undecided_count),
        .consensus    (consensus),
        .consensus_op (cons_op)
    );

    assign consensus_opinion = cons_op;

    // next state
    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_next = clr_reg + AW'(1);
                if (clr_reg == AW'(MAX_AGENTS - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (accept)
                    state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                state_next = need_wr2 ? ST_WR2 : ST_IDLE;
            end
            ST_WR2:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        busy      = 1'b1;
        mem_we    = 1'b0;
        mem_waddr = clr_reg;
        mem_wdata = OP_EMPTY;
        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we = 1'b1;
            end
            ST_IDLE:
            begin
                busy = 1'b0;
            end
            ST_EXEC:
            begin
                mem_we    = wr_first;
                mem_waddr = wr_first_b ? ib_reg : ia_reg;
                mem_wdata = wr_first_data;
            end
            ST_WR2:
            begin
                mem_we    = 1'b1;
                mem_waddr = ib_reg;
                mem_wdata = OP_UND;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            done_reg  <= (state_reg == ST_EXEC);
        end
    end

    assign done        = done_reg;
    assign index_error = err_reg;

`ifndef NO_ASSERTIONS
    // totals never count more agents than the store holds
    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (32'(yes_count) + 32'(no_count) + 32'(undecided_count)) <= 32'(MAX_AGENTS))
        else $error("opinion totals exceed store size");

    // a result strobe only follows the execute state
    a_done_src: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == ST_EXEC))
        else $error("result strobe without execute");

    // second write only right after execute of a yes-no pair
    a_wr2_src: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_WR2 |-> $past(state_reg == ST_EXEC && need_wr2))
        else $error("second write out of sequence");

    // a rejected word never touches the store
    a_err_nowrite: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EXEC && err_reg) |-> !mem_we)
        else $error("store written on index error");

    // no word is taken during the clearing sweep
    a_clear_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CLEAR |-> busy)
        else $error("idle during store clear");
`endif

endmodule

// ===== verif/mps_checker.sv =====
// checker for the majority protocol block: predicts every result word and compares it
// depends on mps_pkg; watches the command, config and result ports from outside
`timescale 1ns / 1ps

module mps_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic                       busy,
    input  logic                       func,
    input  logic [mps_pkg::AW-1:0]     index_a,
    input  logic [mps_pkg::AW-1:0]     index_b,
    input  logic [1:0]                 new_opinion,
    input  logic                       cfg_valid,
    input  logic                       cfg_ready,
    input  logic [mps_pkg::CFG_W-1:0]  cfg_data,
    input  logic                       done,
    input  logic [mps_pkg::CW-1:0]     yes_count,
    input  logic [mps_pkg::CW-1:0]     no_count,
    input  logic [mps_pkg::CW-1:0]     undecided_count,
    input  logic                       consensus,
    input  logic [1:0]                 consensus_opinion,
    input  logic                       index_error,
    output int                         fail_count,
    output int                         pending
);
    import mps_pkg::*;

    typedef struct {
        logic [CW-1:0] yes_n;
        logic [CW-1:0] no_n;
        logic [CW-1:0] und_n;
        logic          cons;
        logic [1:0]    cons_op;
        logic          err;
    } tally_t;

    opinion_t        agent_op [MAX_AGENTS];
    logic [CW-1:0]   yes_tot;
    logic [CW-1:0]   no_tot;
    logic [CW-1:0]   und_tot;
    logic [CFG_W-1:0] agent_cnt;
    tally_t          tally_q [$];
    tally_t          fresh;
    tally_t          oldest;
    int              mismatches;

    function automatic int agents_in_use();
        int c;
        c = int'(agent_cnt);
        if (c < 1)
            c = 1;
        if (c > MAX_AGENTS)
            c = MAX_AGENTS;
        return c;
    endfunction

    // totals never go below zero
    task automatic bump_total(input opinion_t op, input bit up);
        case (op)
            OP_YES:  yes_tot = up ? yes_tot + 1'b1 : (yes_tot != 0 ? yes_tot - 1'b1 : yes_tot);
            OP_NO:   no_tot  = up ? no_tot + 1'b1  : (no_tot != 0  ? no_tot - 1'b1  : no_tot);
            OP_UND:  und_tot = up ? und_tot + 1'b1 : (und_tot != 0 ? und_tot - 1'b1 : und_tot);
            default: ;
        endcase
    endtask

    task automatic place_opinion(input int idx, input opinion_t op);
        bump_total(agent_op[idx], 1'b0);
        agent_op[idx] = op;
        bump_total(op, 1'b1);
    endtask

    task automatic apply_word(input logic fn, input logic [AW-1:0] ia,
                              input logic [AW-1:0] ib, input logic [1:0] op,
                              output tally_t t);
        int       cnt;
        opinion_t a;
        opinion_t b;
        logic     err;
        cnt = agents_in_use();
        if (fn == FN_WRITE)
        begin
            err = int'(ia) >= cnt;
            if (!err)
                place_opinion(int'(ia), opinion_t'(op));
        end
        else
        begin
            err = (int'(ia) >= cnt) || (int'(ib) >= cnt);
            if (!err && ia != ib)
            begin
                a = agent_op[ia];
                b = agent_op[ib];
                if ((a == OP_YES || a == OP_NO) && b == OP_UND)
                    place_opinion(int'(ib), a);
                else if (a == OP_UND && (b == OP_YES || b == OP_NO))
                    place_opinion(int'(ia), b);
                else if ((a == OP_YES && b == OP_NO) || (a == OP_NO && b == OP_YES))
                begin
                    place_opinion(int'(ia), OP_UND);
                    place_opinion(int'(ib), OP_UND);
                end
            end
        end
        t.yes_n   = yes_tot;
        t.no_n    = no_tot;
        t.und_n   = und_tot;
        t.err     = err;
        t.cons    = 1'b1;
        t.cons_op = OP_YES;
        // yes wins over no, no over undecided
        if (int'(yes_tot) == cnt)
            t.cons_op = OP_YES;
        else if (int'(no_tot) == cnt)
            t.cons_op = OP_NO;
        else if (int'(und_tot) == cnt)
            t.cons_op = OP_UND;
        else
        begin
            t.cons    = 1'b0;
            t.cons_op = OP_YES;
        end
    endtask

    task automatic report_mismatch(input string field, input int got, input int want);
        $display("[%0t] mismatch on %s: got %0d, want %0d", $realtime, field, got, want);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_AGENTS; i++)
                agent_op[i] = OP_EMPTY;
            yes_tot    = '0;
            no_tot     = '0;
            und_tot    = '0;
            agent_cnt  = CFG_W'(CFG_RESET);
            mismatches = 0;
            tally_q.delete();
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                agent_cnt = cfg_data;
            if (start && !busy)
            begin
                apply_word(func, index_a, index_b, new_opinion, fresh);
                tally_q = {tally_q, fresh};
            end
            if (done)
            begin
                if (tally_q.size() == 0)
                    report_mismatch("result word with nothing pending", 1, 0);
                else
                begin
                    oldest = tally_q.pop_front();
                    if (yes_count !== oldest.yes_n)
                        report_mismatch("yes_count", yes_count, oldest.yes_n);
                    if (no_count !== oldest.no_n)
                        report_mismatch("no_count", no_count, oldest.no_n);
                    if (undecided_count !== oldest.und_n)
                        report_mismatch("undecided_count", undecided_count, oldest.und_n);
                    if (consensus !== oldest.cons)
                        report_mismatch("consensus", consensus, oldest.cons);
                    if (consensus_opinion !== oldest.cons_op)
                        report_mismatch("consensus_opinion", consensus_opinion,
                                        oldest.cons_op);
                    if (index_error !== oldest.err)
                        report_mismatch("index_error", index_error, oldest.err);
                end
            end
            fail_count <= mismatches;
            pending    <= tally_q.size();
        end
    end

endmodule

// ===== verif/tb_top.sv =====
// top of the majority protocol testbench: clock, reset, command and config stimulus, verdict
// depends on mps_pkg, majority_protocol_simulator and mps_checker
`timescale 1ns / 1ps

module tb_top;
    import mps_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic              func = 1'b0;
    logic [AW-1:0]     index_a = '0;
    logic [AW-1:0]     index_b = '0;
    logic [1:0]        new_opinion = '0;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [CFG_W-1:0]  cfg_data = '0;
    logic              done;
    logic [CW-1:0]     yes_count;
    logic [CW-1:0]     no_count;
    logic [CW-1:0]     undecided_count;
    logic              consensus;
    logic [1:0]        consensus_opinion;
    logic              index_error;
    int                chk_fails;
    int                chk_pending;
    int                cycles = 0;
    int                used_cnt = CFG_RESET;

    majority_protocol_simulator DUT (
        .clk               (clk),
        .rst_n             (rst_n),
        .start             (start),
        .busy              (busy),
        .func              (func),
        .index_a           (index_a),
        .index_b           (index_b),
        .new_opinion       (new_opinion),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_data          (cfg_data),
        .done              (done),
        .yes_count         (yes_count),
        .no_count          (no_count),
        .undecided_count   (undecided_count),
        .consensus         (consensus),
        .consensus_opinion (consensus_opinion),
        .index_error       (index_error)
    );

    mps_checker u_checker (
        .clk               (clk),
        .rst_n             (rst_n),
        .start             (start),
        .busy              (busy),
        .func              (func),
        .index_a           (index_a),
        .index_b           (index_b),
        .new_opinion       (new_opinion),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_data          (cfg_data),
        .done              (done),
        .yes_count         (yes_count),
        .no_count          (no_count),
        .undecided_count   (undecided_count),
        .consensus         (consensus),
        .consensus_opinion (consensus_opinion),
        .index_error       (index_error),
        .fail_count        (chk_fails),
        .pending           (chk_pending)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // start stays high across back-to-back words; it drops only for a gap
    task automatic send_word(input logic fn, input int a, input int b, input int op,
                             input int idle_pct);
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < idle_pct)
                @(posedge clk);
        end
        start       <= 1'b1;
        func        <= fn;
        index_a     <= AW'(a);
        index_b     <= AW'(b);
        new_opinion <= 2'(op);
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // wait until every word has come back and the block is idle again
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (chk_pending != 0 || busy)
            @(posedge clk);
        repeat (6) @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic write_count(input int v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= CFG_W'(v);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        used_cnt = v < 1 ? 1 : (v > MAX_AGENTS ? MAX_AGENTS : v);
    endtask

    // mostly the first few agents, so that interactions meet populated agents
    function automatic int pick_index();
        if ($urandom_range(1))
            return $urandom_range(used_cnt - 1);
        return $urandom_range((used_cnt < 16 ? used_cnt : 16) - 1);
    endfunction

    task automatic run_random(input int n, input int idle_pct);
        int   r;
        int   a;
        int   b;
        int   op;
        logic fn;
        for (int k = 0; k < n; k++) begin
            r  = $urandom_range(99);
            fn = ($urandom_range(99) < 35) ? FN_WRITE : FN_INTERACT;
            if (r < 8) begin
                a = $urandom_range(MAX_AGENTS - 1);
                b = $urandom_range(MAX_AGENTS - 1);
            end
            else if (r < 11 && used_cnt < MAX_AGENTS) begin
                // one index right at the count
                a = $urandom_range(1) ? used_cnt : pick_index();
                b = (a == used_cnt) ? pick_index() : used_cnt;
            end
            else begin
                a = pick_index();
                b = pick_index();
            end
            op = ($urandom_range(15) == 0) ? OP_EMPTY : $urandom_range(2);
            send_word(fn, a, b, op, idle_pct);
        end
    endtask

    initial begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        // store sweep after reset
        repeat (2) @(posedge clk);
        while (busy)
            @(posedge clk);

        send_word(FN_WRITE,    0,    0,    OP_YES,   0);
        send_word(FN_WRITE,    1,    0,    OP_NO,    0);
        send_word(FN_WRITE,    2,    0,    OP_UND,   0);
        send_word(FN_INTERACT, 0,    2,    OP_YES,   0);
        send_word(FN_WRITE,    2,    0,    OP_UND,   0);
        send_word(FN_INTERACT, 2,    1,    OP_YES,   0);
        send_word(FN_INTERACT, 0,    1,    OP_YES,   0);
        send_word(FN_INTERACT, 3,    3,    OP_YES,   0);
        send_word(FN_INTERACT, 3,    0,    OP_YES,   0);
        send_word(FN_WRITE,    1023, 1023, OP_YES,   0);
        send_word(FN_INTERACT, 1023, 0,    OP_UND,   0);
        send_word(FN_WRITE,    1023, 0,    OP_EMPTY, 0);
        send_word(FN_WRITE,    0,    1023, OP_NO,    0);
        write_count(2);
        send_word(FN_WRITE,    2,    0,    OP_YES,   0);
        send_word(FN_INTERACT, 1,    1023, OP_YES,   0);
        write_count(4);
        send_word(FN_WRITE,    2,    0,    OP_YES,   0);
        send_word(FN_WRITE,    3,    0,    OP_YES,   0);
        send_word(FN_WRITE,    1,    0,    OP_NO,    0);
        // yes and no both reach the lowered count
        write_count(2);
        send_word(FN_INTERACT, 0,    0,    OP_YES,   0);
        send_word(FN_WRITE,    0,    0,    OP_EMPTY, 0);
        write_count(4);
        for (int i = 0; i < 4; i++)
            send_word(FN_WRITE, i, 0, OP_EMPTY, 0);

        // counts grow from phase to phase up to the last, random one, so earlier agents stay in range until then
        write_count(0);
        run_random(100, 0);
        write_count(1);
        run_random(150, 79);
        write_count(2);
        run_random(150, 32);
        write_count(3);
        run_random(250, 0);
        write_count(8);
        run_random(300, 79);
        write_count(16);
        run_random(300, 32);
        write_count(2047);
        run_random(250, 0);
        write_count($urandom_range(2047));
        run_random(300, 79);

        drain();
        if (chk_fails == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
